/* rtl/gnncc_pkg.sv */
// gnncc_pkg: shared types and constants of the cone chain block
// holds request structs, widths and register indexes; no dependencies
`default_nettype none
package gnncc_pkg;

  localparam int MAX_CONES  = 64;
  localparam int COORD_BITS = 20;
  localparam int IDX_W      = $clog2(MAX_CONES);
  localparam int CNT_W      = $clog2(MAX_CONES + 1);
  localparam int GAP_W      = 16;
  // coordinate difference, its square sum and the dot product
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int DSQ_W      = PROD_W;
  localparam int DOT_W      = PROD_W + 1;
  // serial multiplier operand width
  localparam int SM_W       = DOT_W;
  localparam int SM_CNT_W   = $clog2(SM_W + 1);
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP = 2'd3;

  localparam logic [GAP_W-1:0] MIN_GAP_RST = 16'd256;
  localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd1920;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cone_x;
    logic signed [COORD_BITS-1:0] cone_y;
    logic                         last_cone;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_valid;
    logic                         out_last;
    logic                         overflow;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } cone_t;

  localparam int CONE_W = $bits(cone_t);

  // serial multiplier status
  typedef struct packed {
    logic busy;
    logic done;
  } smul_stat_t;

endpackage
`default_nettype wire

/* rtl/gnncc_ram.sv */
// gnncc_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module gnncc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/gnncc_smul.sv */
// gnncc_smul: shift-add unsigned multiplier, one operand bit per cycle
// depends on gnncc_pkg for widths and the status struct
`default_nettype none
module gnncc_smul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [gnncc_pkg::SM_W-1:0]   a,
  input  wire logic [gnncc_pkg::SM_W-1:0]   b,
  output gnncc_pkg::smul_stat_t             stat,
  output logic [2*gnncc_pkg::SM_W-1:0]      prod
);

  logic [gnncc_pkg::SM_W-1:0]     a_r;
  logic [2*gnncc_pkg::SM_W-1:0]   acc_r, acc_nxt;
  logic [gnncc_pkg::SM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [gnncc_pkg::SM_W:0]       sum;

  // one partial product per cycle, shift right
  always_comb begin
    sum      = {1'b0, acc_r[2*gnncc_pkg::SM_W-1:gnncc_pkg::SM_W]}
             + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      acc_nxt = {{gnncc_pkg::SM_W{1'b0}}, b};
      cnt_nxt = gnncc_pkg::SM_CNT_W'(gnncc_pkg::SM_W);
    end else if (cnt_r != '0) begin
      acc_nxt  = {sum, acc_r[gnncc_pkg::SM_W-1:1]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == gnncc_pkg::SM_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (go) begin
      a_r <= a;
    end
  end

  assign prod      = acc_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule
`default_nettype wire

/* rtl/gated_nearest_neighbor_cone_chain.sv */
// gated_nearest_neighbor_cone_chain: greedy nearest neighbor cone chaining
// a cone without last_cone is only stored; a final cone runs one chain step per
// loaded cone but the last: a scan of the set, a pick, and, from the third accepted
// cone on, a heading check through the serial multiplier; busy holds requests
// results are single-cycle strobes, the receiver cannot stall; sync active-low reset
// clears the set and control state; depends on gnncc_pkg, gnncc_ram, gnncc_smul
`default_nettype none
module gated_nearest_neighbor_cone_chain (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire gnncc_pkg::in_t                    in_req,
  output logic                                   out_strobe,
  output gnncc_pkg::out_t                        out_req,
  input  wire logic                              cfg_we,
  input  wire logic [gnncc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [gnncc_pkg::COORD_BITS-1:0]  cfg_wdata
);

  localparam int CB = gnncc_pkg::COORD_BITS;
  localparam int DW = gnncc_pkg::DIFF_W;
  localparam int PW = gnncc_pkg::PROD_W;
  localparam int QW = gnncc_pkg::DSQ_W;
  localparam int TW = gnncc_pkg::DOT_W;
  localparam int SW = gnncc_pkg::SM_W;
  localparam int NW = gnncc_pkg::CNT_W;
  localparam int IW = gnncc_pkg::IDX_W;
  localparam int GW = gnncc_pkg::GAP_W;
  localparam int MC = gnncc_pkg::MAX_CONES;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SCAN = 8'b0000_0010,
    ST_PICK = 8'b0000_0100,
    ST_DOT  = 8'b0000_1000,
    ST_DSUM = 8'b0001_0000,
    ST_SQ   = 8'b0010_0000,
    ST_PROD = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic signed [CB-1:0] start_x_r, start_y_r;
  logic [GW-1:0]        min_gap_r, max_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      min_gap_r <= gnncc_pkg::MIN_GAP_RST;
      max_gap_r <= gnncc_pkg::MAX_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        gnncc_pkg::REG_START_X: start_x_r <= cfg_wdata;
        gnncc_pkg::REG_START_Y: start_y_r <= cfg_wdata;
        gnncc_pkg::REG_MIN_GAP: min_gap_r <= cfg_wdata[GW-1:0];
        gnncc_pkg::REG_MAX_GAP: max_gap_r <= cfg_wdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // set and chain state
  logic [MC-1:0]        mask_r, mask_nxt;
  logic [NW-1:0]        ld_r, ld_nxt;
  logic [NW-1:0]        rem_r, rem_nxt;
  logic [NW-1:0]        acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic signed [CB-1:0] anc_x_r, anc_x_nxt, anc_y_r, anc_y_nxt;
  logic signed [DW-1:0] hd_x_r, hd_x_nxt, hd_y_r, hd_y_nxt;
  logic [QW-1:0]        hsq_r, hsq_nxt;
  logic signed [DW-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic                 pend_r, pend_nxt;
  logic signed [CB-1:0] pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [2*SW-1:0]      dsq_r, dsq_nxt;

  // scan pipeline
  logic [NW-1:0]        sidx_r, sidx_nxt;
  logic                 iss_r, iss_nxt;
  logic [IW-1:0]        iss_idx_r;
  logic                 sa_r, sb_r;
  logic [IW-1:0]        sa_idx_r, sb_idx_r;
  gnncc_pkg::cone_t     sa_cone_r, sb_cone_r;
  logic signed [DW-1:0] sa_dx_r, sa_dy_r;
  logic signed [PW-1:0] p0_r, p1_r;
  logic                 found_r, found_nxt;
  logic [QW-1:0]        bd_r, bd_nxt;
  logic [IW-1:0]        bi_r, bi_nxt;
  gnncc_pkg::cone_t     bc_r, bc_nxt;

  // output register
  logic                 out_stb_r, out_stb_nxt;
  gnncc_pkg::out_t      out_r, out_nxt;

  // memory
  logic                 ram_we;
  logic [IW-1:0]        ram_addr;
  gnncc_pkg::cone_t     ram_wdata, ram_rdata;

  // serial multiplier
  logic                  sm_go;
  logic [SW-1:0]         sm_a, sm_b;
  gnncc_pkg::smul_stat_t sm_stat;
  logic [2*SW-1:0]       sm_prod;

  logic                 accept;
  logic                 room;
  logic [NW-1:0]        ld_new;
  logic signed [DW-1:0] rd_dx, rd_dy;
  logic signed [DW-1:0] m_a0, m_b0, m_a1, m_b1;
  logic [QW-1:0]        d_sum;
  logic signed [DW-1:0] pk_vx, pk_vy;
  logic [NW-1:0]        rem_dec;
  logic [2*GW-1:0]      lo_sq, hi_sq;
  logic                 gap_ok;
  logic signed [TW-1:0] dot;
  logic                 scan_done;
  logic                 take, reject;
  logic signed [DW-1:0] tk_hx, tk_hy;
  logic                 tk_head;
  logic [QW-1:0]        tk_hsq;
  logic [NW-1:0]        rem_after;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign room   = (ld_r < NW'(MC));
  assign ld_new = room ? ld_r + 1'b1 : ld_r;

  assign ram_we    = accept && room;
  assign ram_wdata = '{x: in_req.cone_x, y: in_req.cone_y};
  assign ram_addr  = (state_r == ST_SCAN) ? sidx_r[IW-1:0] : ld_r[IW-1:0];

  gnncc_ram #(
    .WIDTH (gnncc_pkg::CONE_W),
    .DEPTH (MC)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // distance from anchor of the cone just read
  assign rd_dx = DW'(ram_rdata.x) - DW'(anc_x_r);
  assign rd_dy = DW'(ram_rdata.y) - DW'(anc_y_r);

  // shared multiplier pair: heading dot in the dot state, squares otherwise
  always_comb begin
    if (state_r == ST_DOT) begin
      m_a0 = hd_x_r;
      m_b0 = vx_r;
      m_a1 = hd_y_r;
      m_b1 = vy_r;
    end else begin
      m_a0 = sa_dx_r;
      m_b0 = sa_dx_r;
      m_a1 = sa_dy_r;
      m_b1 = sa_dy_r;
    end
  end

  assign d_sum = QW'(unsigned'(p0_r)) + QW'(unsigned'(p1_r));
  assign dot   = TW'(p0_r) + TW'(p1_r);

  // pick step values
  assign pk_vx   = DW'(bc_r.x) - DW'(anc_x_r);
  assign pk_vy   = DW'(bc_r.y) - DW'(anc_y_r);
  assign rem_dec = rem_r - 1'b1;
  assign lo_sq   = min_gap_r * min_gap_r;
  assign hi_sq   = max_gap_r * max_gap_r;
  assign gap_ok  = (bd_r > QW'(lo_sq)) && (bd_r < QW'(hi_sq));

  assign scan_done = (sidx_r >= ld_r) && !iss_r && !sa_r && !sb_r;

  gnncc_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sm_go),
    .a     (sm_a),
    .b     (sm_b),
    .stat  (sm_stat),
    .prod  (sm_prod)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    mask_nxt    = mask_r;
    ld_nxt      = ld_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    ovf_nxt     = ovf_r;
    anc_x_nxt   = anc_x_r;
    anc_y_nxt   = anc_y_r;
    hd_x_nxt    = hd_x_r;
    hd_y_nxt    = hd_y_r;
    hsq_nxt     = hsq_r;
    vx_nxt      = vx_r;
    vy_nxt      = vy_r;
    pend_nxt    = pend_r;
    pend_x_nxt  = pend_x_r;
    pend_y_nxt  = pend_y_r;
    dsq_nxt     = dsq_r;
    sidx_nxt    = sidx_r;
    iss_nxt     = 1'b0;
    found_nxt   = found_r;
    bd_nxt      = bd_r;
    bi_nxt      = bi_r;
    bc_nxt      = bc_r;
    out_stb_nxt = 1'b0;
    out_nxt     = out_r;
    sm_go       = 1'b0;
    sm_a        = '0;
    sm_b        = '0;
    take        = 1'b0;
    reject      = 1'b0;
    tk_head     = 1'b0;
    tk_hx       = vx_r;
    tk_hy       = vy_r;
    tk_hsq      = bd_r;
    rem_after   = rem_r;

    // best candidate update at the end of the scan pipe
    if (sb_r && (!found_r || d_sum < bd_r)) begin
      found_nxt = 1'b1;
      bd_nxt    = d_sum;
      bi_nxt    = sb_idx_r;
      bc_nxt    = sb_cone_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (room) begin
            mask_nxt[ld_r[IW-1:0]] = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          ld_nxt = ld_new;
          if (in_req.last_cone) begin
            anc_x_nxt = start_x_r;
            anc_y_nxt = start_y_r;
            acc_nxt   = '0;
            rem_nxt   = ld_new;
            pend_nxt  = 1'b0;
            sidx_nxt  = '0;
            found_nxt = 1'b0;
            state_nxt = (ld_new > NW'(1)) ? ST_SCAN : ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (sidx_r < ld_r) begin
          iss_nxt  = mask_r[sidx_r[IW-1:0]];
          sidx_nxt = sidx_r + 1'b1;
        end
        if (scan_done) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        mask_nxt[bi_r] = 1'b0;
        rem_nxt        = rem_dec;
        rem_after      = rem_dec;
        vx_nxt         = pk_vx;
        vy_nxt         = pk_vy;
        if (acc_r == '0) begin
          take = 1'b1;
        end else if (!gap_ok) begin
          reject = 1'b1;
        end else if (acc_r == NW'(1)) begin
          take    = 1'b1;
          tk_head = 1'b1;
          tk_hx   = pk_vx;
          tk_hy   = pk_vy;
        end else begin
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: begin
        state_nxt = ST_DSUM;
      end
      ST_DSUM: begin
        if (dot[TW-1] || dot == '0) begin
          reject = 1'b1;
        end else begin
          sm_go     = 1'b1;
          sm_a      = SW'(unsigned'(dot));
          sm_b      = SW'(unsigned'(dot));
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (sm_stat.done) begin
          dsq_nxt   = sm_prod;
          sm_go     = 1'b1;
          sm_a      = SW'(hsq_r);
          sm_b      = SW'(bd_r);
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        if (sm_stat.done) begin
          if ({dsq_r[2*SW-3:0], 2'b00} > sm_prod) begin
            take    = 1'b1;
            tk_head = 1'b1;
          end else begin
            reject = 1'b1;
          end
        end
      end
      ST_FIN: begin
        out_stb_nxt       = 1'b1;
        out_nxt.out_x     = pend_r ? pend_x_r : '0;
        out_nxt.out_y     = pend_r ? pend_y_r : '0;
        out_nxt.out_valid = pend_r;
        out_nxt.out_last  = 1'b1;
        out_nxt.overflow  = ovf_r;
        mask_nxt          = '0;
        ld_nxt            = '0;
        ovf_nxt           = 1'b0;
        acc_nxt           = '0;
        pend_nxt          = 1'b0;
        anc_x_nxt         = '0;
        anc_y_nxt         = '0;
        hd_x_nxt          = '0;
        hd_y_nxt          = '0;
        state_nxt         = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // accepted pick: release the held result, hold this one
    if (take) begin
      if (pend_r) begin
        out_stb_nxt       = 1'b1;
        out_nxt.out_x     = pend_x_r;
        out_nxt.out_y     = pend_y_r;
        out_nxt.out_valid = 1'b1;
        out_nxt.out_last  = 1'b0;
        out_nxt.overflow  = ovf_r;
      end
      pend_nxt   = 1'b1;
      pend_x_nxt = bc_r.x;
      pend_y_nxt = bc_r.y;
      anc_x_nxt  = bc_r.x;
      anc_y_nxt  = bc_r.y;
      acc_nxt    = acc_r + 1'b1;
      if (tk_head) begin
        hd_x_nxt = tk_hx;
        hd_y_nxt = tk_hy;
        hsq_nxt  = tk_hsq;
      end
    end

    // next chain step or wrap up
    if (take || reject) begin
      sidx_nxt  = '0;
      found_nxt = 1'b0;
      state_nxt = (rem_after > NW'(1)) ? ST_SCAN : ST_FIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mask_r    <= '0;
      ld_r      <= '0;
      rem_r     <= '0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      anc_x_r   <= '0;
      anc_y_r   <= '0;
      hd_x_r    <= '0;
      hd_y_r    <= '0;
      pend_r    <= 1'b0;
      sidx_r    <= '0;
      iss_r     <= 1'b0;
      sa_r      <= 1'b0;
      sb_r      <= 1'b0;
      found_r   <= 1'b0;
      out_stb_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mask_r    <= mask_nxt;
      ld_r      <= ld_nxt;
      rem_r     <= rem_nxt;
      acc_r     <= acc_nxt;
      ovf_r     <= ovf_nxt;
      anc_x_r   <= anc_x_nxt;
      anc_y_r   <= anc_y_nxt;
      hd_x_r    <= hd_x_nxt;
      hd_y_r    <= hd_y_nxt;
      pend_r    <= pend_nxt;
      sidx_r    <= sidx_nxt;
      iss_r     <= iss_nxt;
      sa_r      <= iss_r;
      sb_r      <= sa_r;
      found_r   <= found_nxt;
      out_stb_r <= out_stb_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hsq_r     <= hsq_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    pend_x_r  <= pend_x_nxt;
    pend_y_r  <= pend_y_nxt;
    dsq_r     <= dsq_nxt;
    bd_r      <= bd_nxt;
    bi_r      <= bi_nxt;
    bc_r      <= bc_nxt;
    out_r     <= out_nxt;
    iss_idx_r <= sidx_r[IW-1:0];
    sa_idx_r  <= iss_idx_r;
    sa_cone_r <= ram_rdata;
    sa_dx_r   <= rd_dx;
    sa_dy_r   <= rd_dy;
    sb_idx_r  <= sa_idx_r;
    sb_cone_r <= sa_cone_r;
    p0_r      <= m_a0 * m_b0;
    p1_r      <= m_a1 * m_b1;
  end

  assign out_strobe = out_stb_r;
  assign out_req    = out_r;

  // scan pipe only runs during a scan
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!iss_r && !sa_r && !sb_r))
    else $error("scan pipe active while idle");

  // the final result closes the chain and frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stb_r && out_r.out_last) |-> (state_r == ST_IDLE))
    else $error("final result while chain still running");

  // an empty-chain request is always the final one
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stb_r && !out_r.out_valid) |-> out_r.out_last)
    else $error("invalid request not marked last");

  // accepted cones never exceed loaded cones
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ld_r)
    else $error("accepted count beyond loaded count");

  // serial multiplier only works inside the heading check
  a_smul_use: assert property (@(posedge clk) disable iff (!rst_n)
    sm_stat.busy |-> (state_r == ST_SQ || state_r == ST_PROD))
    else $error("multiplier busy outside heading check");

endmodule
`default_nettype wire
